// ===== hw/rtl/acl_pkg.sv =====
package acl_pkg;

    // Field widths of the request and result items.
    localparam int LIFE_W = 16;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int EXP_W  = 5;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;

    // Lifetime register value after reset, in ticks.
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd1200;

    // Request kinds.
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERT = 3'd2;
    localparam logic [STAT_W-1:0] ST_EVICT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd4;
    localparam logic [STAT_W-1:0] ST_TICK   = 3'd5;
    localparam logic [STAT_W-1:0] ST_BAD    = 3'd6;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_INC = 2'd0,
        ALU_DEC = 2'd1,
        ALU_SUB = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [LIFE_W-1:0] a;
        logic [LIFE_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [LIFE_W-1:0] res;
        logic              lt;
    } alu_rsp_t;

    // Write strobes from the sequencer to the entry store.
    typedef struct packed {
        logic ip_we;
        logic mac_we;
        logic life_we;
        logic rank_we;
        logic shift_we;
        logic valid_set;
        logic valid_clr;
    } wr_ctl_t;

endpackage

// ===== hw/rtl/acl_alu.sv =====
module acl_alu (
    input  acl_pkg::alu_req_t req,
    output acl_pkg::alu_rsp_t rsp
);
    import acl_pkg::*;

    // One adder and one magnitude compare, shared by the age, lifetime and rank passes.
    always_comb begin
        rsp.lt = (req.a < req.b);
        unique case (req.op)
            ALU_INC: begin
                rsp.res = req.a + LIFE_W'(1);
            end
            ALU_DEC: begin
                rsp.res = req.a - LIFE_W'(1);
            end
            ALU_SUB: begin
                rsp.res = req.a - req.b;
            end
            default: begin
                rsp.res = req.a;
            end
        endcase
    end

endmodule

// ===== hw/rtl/acl_store.sv =====
module acl_store #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [IW-1:0]             rd_addr,
    input  logic [IW-1:0]             shift_raddr,
    input  acl_pkg::wr_ctl_t          wr,
    input  logic [IW-1:0]             wr_addr,
    input  logic [acl_pkg::IP_W-1:0]  ip_wd,
    input  logic [acl_pkg::MAC_W-1:0] mac_wd,
    input  logic [acl_pkg::LIFE_W-1:0] life_wd,
    input  logic [IW-1:0]             rank_wd,
    input  logic [IW-1:0]             shift_wd,
    output logic [DEPTH-1:0]          valid_vec,
    output logic [acl_pkg::IP_W-1:0]  ip_q,
    output logic [acl_pkg::MAC_W-1:0] mac_q,
    output logic [acl_pkg::LIFE_W-1:0] life_q,
    output logic [IW-1:0]             rank_q,
    output logic [IW-1:0]             shift_q
);
    import acl_pkg::*;

    logic [IP_W-1:0]   ip_mem    [DEPTH];
    logic [MAC_W-1:0]  mac_mem   [DEPTH];
    logic [LIFE_W-1:0] life_mem  [DEPTH];
    logic [IW-1:0]     rank_mem  [DEPTH];
    logic [IW-1:0]     shift_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;

    // Entry memories: one write port, one registered read port each.
    always_ff @(posedge aclk) begin
        if (wr.ip_we) begin
            ip_mem[wr_addr] <= ip_wd;
        end
        if (wr.mac_we) begin
            mac_mem[wr_addr] <= mac_wd;
        end
        if (wr.life_we) begin
            life_mem[wr_addr] <= life_wd;
        end
        if (wr.rank_we) begin
            rank_mem[wr_addr] <= rank_wd;
        end
        ip_q   <= ip_mem[rd_addr];
        mac_q  <= mac_mem[rd_addr];
        life_q <= life_mem[rd_addr];
        rank_q <= rank_mem[rd_addr];
    end

    // Rank correction table, filled during a tick and read by rank.
    always_ff @(posedge aclk) begin
        if (wr.shift_we) begin
            shift_mem[wr_addr] <= shift_wd;
        end
        shift_q <= shift_mem[shift_raddr];
    end

    // Valid bits live in flops so that reset empties the table at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.valid_set) begin
            valid_reg[wr_addr] <= 1'b1;
        end else if (wr.valid_clr) begin
            valid_reg[wr_addr] <= 1'b0;
        end
    end

    assign valid_vec = valid_reg;

endmodule

// ===== hw/rtl/acl_ctrl.sv =====
module acl_ctrl #(
    parameter int DEPTH = 16,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request side
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [acl_pkg::ACT_W-1:0]  in_action,
    input  logic [acl_pkg::IP_W-1:0]   in_ip,
    input  logic [acl_pkg::MAC_W-1:0]  in_mac,
    input  logic [acl_pkg::LIFE_W-1:0] lifetime,
    // result side
    input  logic                       out_free,
    output logic                       done,
    output logic [acl_pkg::STAT_W-1:0] res_status,
    output logic [acl_pkg::MAC_W-1:0]  res_mac,
    output logic [acl_pkg::EXP_W-1:0]  res_exp,
    // entry store
    output logic [IW-1:0]              rd_addr,
    output logic [IW-1:0]              shift_raddr,
    output acl_pkg::wr_ctl_t           wr,
    output logic [IW-1:0]              wr_addr,
    output logic [acl_pkg::IP_W-1:0]   ip_wd,
    output logic [acl_pkg::MAC_W-1:0]  mac_wd,
    output logic [acl_pkg::LIFE_W-1:0] life_wd,
    output logic [IW-1:0]              rank_wd,
    output logic [IW-1:0]              shift_wd,
    input  logic [DEPTH-1:0]           valid_vec,
    input  logic [acl_pkg::IP_W-1:0]   ip_q,
    input  logic [acl_pkg::MAC_W-1:0]  mac_q,
    input  logic [acl_pkg::LIFE_W-1:0] life_q,
    input  logic [IW-1:0]              rank_q,
    input  logic [IW-1:0]              shift_q,
    // shared arithmetic unit
    output acl_pkg::alu_req_t          alu_req,
    input  acl_pkg::alu_rsp_t          alu_rsp
);
    import acl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_AGE    = 9'b000000100,
        S_FINAL  = 9'b000001000,
        S_MACRD  = 9'b000010000,
        S_LIFE   = 9'b000100000,
        S_PREFIX = 9'b001000000,
        S_RANK   = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg;
    logic                p1_vld_reg;
    logic [IW-1:0]       p1_idx_reg;
    logic                p2_vld_reg;
    logic [IW-1:0]       p2_idx_reg;
    logic [IW-1:0]       p2_rank_reg;
    logic [ACT_W-1:0]    act_reg;
    logic [IP_W-1:0]     ip_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic                found_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic [IW-1:0]       hit_rank_reg;
    logic                free_found_reg;
    logic [IW-1:0]       free_idx_reg;
    logic [IW-1:0]       old_idx_reg;
    logic [IW-1:0]       tgt_reg;
    logic                age_all_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [MAC_W-1:0]    mac_out_reg;
    logic [CW-1:0]       exp_reg;
    logic [CW-1:0]       acc_reg;
    logic [DEPTH-1:0]    removed_reg;

    logic                issue;
    logic                drained;
    logic                v1;

    // A pass issues one entry read a cycle and finishes once its pipe is empty.
    assign issue = ((state_reg == S_SCAN) || (state_reg == S_AGE) ||
                    (state_reg == S_LIFE) || (state_reg == S_RANK)) &&
                   (cnt_reg < CW'(DEPTH));
    assign drained = (cnt_reg == CW'(DEPTH)) && !p1_vld_reg && !p2_vld_reg;
    assign v1 = valid_vec[p1_idx_reg];

    assign in_ready    = (state_reg == S_IDLE);
    assign done        = (state_reg == S_RESP) && out_free;
    assign res_status  = status_reg;
    assign res_mac     = mac_out_reg;
    assign res_exp     = (32'(exp_reg) > 32'd31) ? EXP_W'(31) : EXP_W'(exp_reg);
    assign rd_addr     = (state_reg == S_FINAL) ? tgt_reg : cnt_reg[IW-1:0];
    assign shift_raddr = rank_q;
    assign ip_wd       = ip_reg;
    assign mac_wd      = mac_reg;

    // Operands of the shared unit for the pass under way.
    always_comb begin
        alu_req.op = ALU_INC;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            S_AGE: begin
                alu_req.op = ALU_INC;
                alu_req.a  = LIFE_W'(rank_q);
                alu_req.b  = LIFE_W'(hit_rank_reg);
            end
            S_LIFE: begin
                alu_req.op = ALU_DEC;
                alu_req.a  = life_q;
                alu_req.b  = LIFE_W'(2);
            end
            S_RANK: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = LIFE_W'(p2_rank_reg);
                alu_req.b  = LIFE_W'(shift_q);
            end
            default: begin
                alu_req.op = ALU_INC;
            end
        endcase
    end

    // Store writes for each pass.
    always_comb begin
        wr       = '0;
        wr_addr  = p1_idx_reg;
        life_wd  = alu_rsp.res;
        rank_wd  = alu_rsp.res[IW-1:0];
        shift_wd = acc_reg[IW-1:0];
        unique case (state_reg)
            S_AGE: begin
                // Entries more recent than the target, or all on an insert, grow one step older.
                if (p1_vld_reg && v1 && (p1_idx_reg != tgt_reg) &&
                    (age_all_reg || alu_rsp.lt)) begin
                    wr.rank_we = 1'b1;
                end
            end
            S_LIFE: begin
                // A lifetime of one or zero expires, anything else counts down.
                if (p1_vld_reg && v1) begin
                    if (alu_rsp.lt) begin
                        wr.valid_clr = 1'b1;
                    end else begin
                        wr.life_we = 1'b1;
                    end
                end
            end
            S_PREFIX: begin
                wr_addr = cnt_reg[IW-1:0];
                if (cnt_reg < CW'(DEPTH)) begin
                    wr.shift_we = 1'b1;
                end
            end
            S_RANK: begin
                wr_addr = p2_idx_reg;
                if (p2_vld_reg && valid_vec[p2_idx_reg]) begin
                    wr.rank_we = 1'b1;
                end
            end
            S_FINAL: begin
                // Target becomes most recent with a full lifetime.
                wr_addr     = tgt_reg;
                life_wd     = lifetime;
                rank_wd     = '0;
                wr.rank_we  = 1'b1;
                wr.life_we  = 1'b1;
                if (act_reg == ACT_INSERT) begin
                    wr.ip_we     = 1'b1;
                    wr.mac_we    = 1'b1;
                    wr.valid_set = 1'b1;
                end
            end
            default: begin
                wr = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if ((in_action == ACT_LOOKUP) || (in_action == ACT_INSERT)) begin
                        state_next = S_SCAN;
                    end else if (in_action == ACT_TICK) begin
                        state_next = S_LIFE;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (drained) begin
                    if (act_reg == ACT_LOOKUP) begin
                        state_next = found_reg ? S_AGE : S_RESP;
                    end else begin
                        state_next = found_reg ? S_RESP : S_AGE;
                    end
                end
            end
            S_AGE: begin
                if (drained) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                state_next = (act_reg == ACT_LOOKUP) ? S_MACRD : S_RESP;
            end
            S_MACRD: begin
                state_next = S_RESP;
            end
            S_LIFE: begin
                if (drained) begin
                    state_next = S_PREFIX;
                end
            end
            S_PREFIX: begin
                if (cnt_reg == CW'(DEPTH)) begin
                    state_next = S_RANK;
                end
            end
            S_RANK: begin
                if (drained) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg && (state_reg == S_RANK);
        end
    end

    // Pass counter and per-request working registers.
    always_ff @(posedge aclk) begin
        p1_idx_reg  <= cnt_reg[IW-1:0];
        p2_idx_reg  <= p1_idx_reg;
        p2_rank_reg <= rank_q;
        if (state_next != state_reg) begin
            cnt_reg <= '0;
        end else if (issue || ((state_reg == S_PREFIX) && (cnt_reg < CW'(DEPTH)))) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                act_reg        <= in_action;
                ip_reg         <= in_ip;
                mac_reg        <= in_mac;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                exp_reg        <= '0;
                acc_reg        <= '0;
                removed_reg    <= '0;
                mac_out_reg    <= '0;
                status_reg     <= ST_BAD;
            end
            S_SCAN: begin
                if (p1_vld_reg) begin
                    if (v1 && (ip_q == ip_reg) && !found_reg) begin
                        found_reg    <= 1'b1;
                        hit_idx_reg  <= p1_idx_reg;
                        hit_rank_reg <= rank_q;
                    end
                    if (!v1 && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= p1_idx_reg;
                    end
                    if (v1 && (rank_q == IW'(DEPTH - 1))) begin
                        old_idx_reg <= p1_idx_reg;
                    end
                end
                if (drained) begin
                    if (act_reg == ACT_LOOKUP) begin
                        tgt_reg     <= hit_idx_reg;
                        age_all_reg <= 1'b0;
                        status_reg  <= found_reg ? ST_HIT : ST_MISS;
                    end else begin
                        tgt_reg     <= free_found_reg ? free_idx_reg : old_idx_reg;
                        age_all_reg <= 1'b1;
                        if (found_reg) begin
                            status_reg <= ST_DUP;
                        end else begin
                            status_reg <= free_found_reg ? ST_INSERT : ST_EVICT;
                        end
                    end
                end
            end
            S_MACRD: begin
                mac_out_reg <= mac_q;
            end
            S_LIFE: begin
                if (p1_vld_reg && v1 && alu_rsp.lt) begin
                    removed_reg[rank_q] <= 1'b1;
                    exp_reg             <= exp_reg + CW'(1);
                end
                status_reg <= ST_TICK;
            end
            S_PREFIX: begin
                // Running count of removed ranks below each rank.
                if (cnt_reg < CW'(DEPTH)) begin
                    acc_reg <= acc_reg + CW'(removed_reg[cnt_reg[IW-1:0]]);
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // A request holds the block until its result is in the output register.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    a_p2_in_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_vld_reg |-> ($past(state_reg) == S_RANK))
        else $error("rank pipe active outside rank pass");

    a_set_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.valid_set |-> ((act_reg == ACT_INSERT) &&
                          ((status_reg == ST_INSERT) || (status_reg == ST_EVICT))))
        else $error("slot validated outside an insert");

    a_insert_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.valid_set && (status_reg == ST_INSERT)) |-> !valid_vec[wr_addr])
        else $error("plain insert overwrote a live slot");

    a_expired_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (32'(exp_reg) <= 32'(DEPTH)))
        else $error("expired count exceeds table depth");

endmodule

// ===== hw/rtl/address_cache_lru_aging_unit.sv =====
// Requests are taken one at a time; each pass over the entries walks the table one entry a
// cycle through the single read port of the entry memories, and the age, lifetime and rank
// passes share the one adder and compare.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous) empties the table and loads the lifetime with 1200.
module address_cache_lru_aging_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // ip_address[31:0], mac_address[79:32]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // mac_out[47:0], expired_count[52:48], zero pad[55:53]
    output logic [2:0]  m_tuser,   // status[2:0]
    // lifetime register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import acl_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [LIFE_W-1:0] lifetime_reg;
    logic              m_tvalid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [MAC_W-1:0]  m_mac_reg;
    logic [EXP_W-1:0]  m_exp_reg;

    logic              out_free;
    logic              done;
    logic [STAT_W-1:0] res_status;
    logic [MAC_W-1:0]  res_mac;
    logic [EXP_W-1:0]  res_exp;

    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     shift_raddr;
    wr_ctl_t           wr;
    logic [IW-1:0]     wr_addr;
    logic [IP_W-1:0]   ip_wd;
    logic [MAC_W-1:0]  mac_wd;
    logic [LIFE_W-1:0] life_wd;
    logic [IW-1:0]     rank_wd;
    logic [IW-1:0]     shift_wd;
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [IP_W-1:0]   ip_q;
    logic [MAC_W-1:0]  mac_q;
    logic [LIFE_W-1:0] life_q;
    logic [IW-1:0]     rank_q;
    logic [IW-1:0]     shift_q;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // Lifetime register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg <= LIFETIME_RESET;
        end else if (cfg_wr_en) begin
            lifetime_reg <= cfg_wr_data;
        end
    end

    acl_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_ip       (s_tdata[31:0]),
        .in_mac      (s_tdata[79:32]),
        .lifetime    (lifetime_reg),
        .out_free    (out_free),
        .done        (done),
        .res_status  (res_status),
        .res_mac     (res_mac),
        .res_exp     (res_exp),
        .rd_addr     (rd_addr),
        .shift_raddr (shift_raddr),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .ip_wd       (ip_wd),
        .mac_wd      (mac_wd),
        .life_wd     (life_wd),
        .rank_wd     (rank_wd),
        .shift_wd    (shift_wd),
        .valid_vec   (valid_vec),
        .ip_q        (ip_q),
        .mac_q       (mac_q),
        .life_q      (life_q),
        .rank_q      (rank_q),
        .shift_q     (shift_q),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp)
    );

    acl_store #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_addr     (rd_addr),
        .shift_raddr (shift_raddr),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .ip_wd       (ip_wd),
        .mac_wd      (mac_wd),
        .life_wd     (life_wd),
        .rank_wd     (rank_wd),
        .shift_wd    (shift_wd),
        .valid_vec   (valid_vec),
        .ip_q        (ip_q),
        .mac_q       (mac_q),
        .life_q      (life_q),
        .rank_q      (rank_q),
        .shift_q     (shift_q)
    );

    acl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Output register: holds a result until its transfer completes.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_status_reg <= res_status;
            m_mac_reg    <= res_mac;
            m_exp_reg    <= res_exp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_exp_reg, m_mac_reg};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import acl_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANK_W = $clog2(DEPTH);
    localparam int POOL_SIZE = 24;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int NUM_PHASES = 6;
    // The slowest request is a tick, so it sets the drain time at the end.
    localparam int TICK_CYCLES = 3 * DEPTH + 8;
    // The one encoding of the action field that the block must reject.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cache_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MAC_W-1:0]  mac;
        logic [EXP_W-1:0]  expired;
    } cache_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    // Shadow copy of the table and the lifetime register.
    logic              shadow_valid [DEPTH];
    logic [IP_W-1:0]   shadow_ip [DEPTH];
    logic [MAC_W-1:0]  shadow_mac [DEPTH];
    logic [LIFE_W-1:0] shadow_life [DEPTH];
    logic [RANK_W-1:0] shadow_rank [DEPTH];
    logic [LIFE_W-1:0] shadow_lifetime = LIFETIME_RESET;

    cache_req_t   requests_to_send[$];
    cache_reply_t replies_due[$];
    cache_req_t   next_req;
    cache_reply_t due_reply;
    logic [IP_W-1:0] ip_pool [POOL_SIZE];

    int src_gap = 0;
    int src_idle_pct = 0;
    int sink_stall = 0;
    int sink_idle_pct = 0;
    int error_count = 0;

    always #10 aclk = ~aclk;

    address_cache_lru_aging_unit #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Apply one request to the shadow table and return the reply it must produce.
    function automatic cache_reply_t cache_apply(input logic [ACT_W-1:0] action,
                                                 input logic [IP_W-1:0] ip,
                                                 input logic [MAC_W-1:0] mac);
        cache_reply_t      reply;
        int                found;
        int                free_slot;
        int                oldest;
        int                removed;
        logic [RANK_W-1:0] new_rank [DEPTH];
        reply = '0;
        reply.status = ST_BAD;
        found = -1;
        free_slot = -1;
        oldest = -1;
        removed = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (found < 0 && shadow_valid[i] && shadow_ip[i] == ip) begin
                found = i;
            end
        end
        case (action)
            ACT_LOOKUP: begin
                if (found >= 0) begin
                    // Entries more recent than the hit move one step older.
                    for (int i = 0; i < DEPTH; i++) begin
                        if (shadow_valid[i] && shadow_rank[i] < shadow_rank[found]) begin
                            shadow_rank[i] = shadow_rank[i] + 1'b1;
                        end
                    end
                    shadow_rank[found] = '0;
                    shadow_life[found] = shadow_lifetime;
                    reply.mac = shadow_mac[found];
                    reply.status = ST_HIT;
                end else begin
                    reply.status = ST_MISS;
                end
            end
            ACT_INSERT: begin
                if (found >= 0) begin
                    reply.status = ST_DUP;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (shadow_valid[i]) begin
                            if (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]) begin
                                oldest = i;
                            end
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    // A full table gives up its least recent entry.
                    if (free_slot < 0) begin
                        shadow_valid[oldest] = 1'b0;
                        free_slot = oldest;
                        reply.status = ST_EVICT;
                    end else begin
                        reply.status = ST_INSERT;
                    end
                    for (int i = 0; i < DEPTH; i++) begin
                        if (shadow_valid[i]) begin
                            shadow_rank[i] = shadow_rank[i] + 1'b1;
                        end
                    end
                    shadow_valid[free_slot] = 1'b1;
                    shadow_ip[free_slot] = ip;
                    shadow_mac[free_slot] = mac;
                    shadow_life[free_slot] = shadow_lifetime;
                    shadow_rank[free_slot] = '0;
                end
            end
            ACT_TICK: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (shadow_valid[i]) begin
                        if (shadow_life[i] <= 1) begin
                            shadow_valid[i] = 1'b0;
                            shadow_life[i] = '0;
                            removed++;
                        end else begin
                            shadow_life[i] = shadow_life[i] - 1'b1;
                        end
                    end
                end
                // Survivors are renumbered without gaps, keeping their order.
                for (int i = 0; i < DEPTH; i++) begin
                    new_rank[i] = '0;
                    if (shadow_valid[i]) begin
                        for (int j = 0; j < DEPTH; j++) begin
                            if (shadow_valid[j] && shadow_rank[j] < shadow_rank[i]) begin
                                new_rank[i] = new_rank[i] + 1'b1;
                            end
                        end
                    end
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (shadow_valid[i]) begin
                        shadow_rank[i] = new_rank[i];
                    end
                end
                reply.expired = (removed > 31) ? 5'd31 : removed[EXP_W-1:0];
                reply.status = ST_TICK;
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // Request driver: holds each item until its transfer, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                replies_due.push_back(cache_apply(s_tuser, s_tdata[IP_W-1:0],
                                                  s_tdata[IP_W +: MAC_W]));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    s_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
                    s_tvalid <= 1'b0;
                    src_gap <= $urandom_range(0, 16);
                end else if (requests_to_send.size() > 0) begin
                    next_req = requests_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {next_req.mac, next_req.ip};
                    s_tuser <= next_req.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks every transfer against the oldest reply due.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("reply with no request outstanding: status %0d", m_tuser);
                    error_count++;
                end else begin
                    due_reply = replies_due.pop_front();
                    if (m_tuser !== due_reply.status) begin
                        $error("status: expected %0d, actual %0d", due_reply.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[MAC_W-1:0] !== due_reply.mac) begin
                        $error("mac_out: expected %h, actual %h", due_reply.mac,
                               m_tdata[MAC_W-1:0]);
                        error_count++;
                    end
                    if (m_tdata[MAC_W +: EXP_W] !== due_reply.expired) begin
                        $error("expired_count: expected %0d, actual %0d", due_reply.expired,
                               m_tdata[MAC_W +: EXP_W]);
                        error_count++;
                    end
                end
            end
            if (sink_stall > 0) begin
                m_tready <= 1'b0;
                sink_stall <= sink_stall - 1;
            end else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct) begin
                m_tready <= 1'b0;
                sink_stall <= $urandom_range(0, 16);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input logic [ACT_W-1:0] action, input logic [IP_W-1:0] ip,
                                 input logic [MAC_W-1:0] mac);
        cache_req_t req;
        req.action = action;
        req.ip = ip;
        req.mac = mac;
        requests_to_send.push_back(req);
    endtask

    // Block until every queued request has had its transfer and every reply is in.
    // The check runs on the falling edge, after the clocked blocks have settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (requests_to_send.size() != 0 || s_tvalid || replies_due.size() != 0);
    endtask

    task automatic write_lifetime(input logic [LIFE_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_lifetime = value;
    endtask

    // Mostly addresses from a small pool, so hits, duplicates and evictions are common.
    task automatic queue_random_request();
        int                 pick;
        logic [ACT_W-1:0]   action;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        pick = $urandom_range(99);
        if (pick < 40) begin
            action = ACT_LOOKUP;
        end else if (pick < 75) begin
            action = ACT_INSERT;
        end else if (pick < 95) begin
            action = ACT_TICK;
        end else begin
            action = ACT_UNUSED;
        end
        ip = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(POOL_SIZE - 1)];
        mac = MAC_W'({$urandom, $urandom});
        queue_request(action, ip, mac);
    endtask

    // Generous limit on the whole run.
    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [LIFE_W-1:0] phase_lifetime [NUM_PHASES];
        int                phase_idle [NUM_PHASES];
        phase_lifetime = '{16'd65535, 16'd3, LIFETIME_RESET, 16'd2, 16'd5, 16'd4};
        phase_idle = '{15, 30, 0, 20, 10, 0};
        for (int i = 0; i < DEPTH; i++) begin
            shadow_valid[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            ip_pool[i] = $urandom;
        end
        phase_lifetime[4] = LIFE_W'($urandom_range(2, 9));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, every action, duplicates, eviction of the oldest.
        src_idle_pct = 20;
        sink_idle_pct = 20;
        queue_request(ACT_LOOKUP, 32'h0, 48'h0);
        queue_request(ACT_INSERT, 32'h0, 48'h0);
        queue_request(ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        queue_request(ACT_INSERT, 32'h0, 48'h1234_5678_9ABC);
        queue_request(ACT_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
        queue_request(ACT_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_request(ACT_TICK, 32'h0, 48'h0);
        for (int i = 0; i < DEPTH - 2; i++) begin
            queue_request(ACT_INSERT, 32'hC0A8_0001 + i, MAC_W'({$urandom, $urandom}));
        end
        queue_request(ACT_INSERT, 32'hC0A8_00FF, 48'hA5A5_5A5A_A5A5);
        queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        queue_request(ACT_TICK, 32'hFFFF_FFFF, 48'h0);
        wait_drained();

        // Shortest lifetime: refill the whole table, then one tick empties it.
        write_lifetime(16'd1);
        for (int i = 0; i < DEPTH; i++) begin
            queue_request(ACT_INSERT, 32'h0A00_0000 + i, MAC_W'({$urandom, $urandom}));
        end
        queue_request(ACT_TICK, 32'h0, 48'h0);
        queue_request(ACT_TICK, 32'h0, 48'h0);
        wait_drained();

        // Zero lifetime: entries loaded with zero still go at the next tick.
        write_lifetime(16'd0);
        queue_request(ACT_INSERT, 32'h0B00_0001, MAC_W'({$urandom, $urandom}));
        queue_request(ACT_INSERT, 32'h0B00_0002, MAC_W'({$urandom, $urandom}));
        queue_request(ACT_LOOKUP, 32'h0B00_0001, 48'h0);
        queue_request(ACT_TICK, 32'h0, 48'h0);
        wait_drained();

        // Random phases, each under its own lifetime and idling mix.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_lifetime(phase_lifetime[p]);
            src_idle_pct = phase_idle[p];
            sink_idle_pct = phase_idle[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_random_request();
            end
            wait_drained();
        end

        repeat (2 * TICK_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/acl_pkg.sv
hw/rtl/acl_alu.sv
hw/rtl/acl_store.sv
hw/rtl/acl_ctrl.sv
hw/rtl/address_cache_lru_aging_unit.sv
sim/tb.sv
